[rtl/bpa_pkg.sv]
`default_nettype none

package bpa_pkg;

    // Map geometry. The bitmap is held as rows of ROW_W bits in one memory.
    localparam int NUM_PAGES = 4096;
    localparam int ROW_W     = 64;
    localparam int BYTE_W    = 8;
    localparam int GRP_N     = ROW_W / BYTE_W;
    localparam int GRP_W     = $clog2(GRP_N);
    localparam int BIT_W     = $clog2(BYTE_W);
    localparam int OFF_W     = $clog2(ROW_W);
    localparam int NUM_ROWS  = (NUM_PAGES + ROW_W - 1) / ROW_W;
    localparam int RA_W      = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int PA_W      = RA_W + OFF_W;
    localparam int CNT_W     = $clog2(NUM_PAGES + 1);

    // Field widths of the words on the ports.
    localparam int PG_W      = 12;
    localparam int CNT_OUT_W = 13;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_TEST  = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_FULL         = 2'd1,
        ST_ALREADY_FREE = 2'd2,
        ST_RANGE        = 2'd3
    } t_status;

    typedef struct packed {
        t_opcode           opcode;
        logic [PG_W-1:0]   page_index;
    } t_in_word;

    typedef struct packed {
        t_status              status;
        logic [PG_W-1:0]      granted_page;
        logic                 page_is_free;
        logic [CNT_OUT_W-1:0] used_count;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_APPLY,
        S_SCAN,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic early;
        logic rd_target;
        logic apply;
        logic scan_rd;
        logic scan_hit;
        logic load_out;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic early;
        logic need_scan;
        logic hit;
    } t_ctl_sts;

    // Bits of the last row that lie beyond the end of the map read as used.
    function automatic logic [ROW_W-1:0] last_row_mask();
        logic [ROW_W-1:0] m;
        m = '0;
        for (int b = 0; b < ROW_W; b++) begin
            if ((NUM_ROWS - 1) * ROW_W + b >= NUM_PAGES) begin
                m[b] = 1'b1;
            end
        end
        return m;
    endfunction

    localparam logic [ROW_W-1:0] LAST_MASK = last_row_mask();

    // Position of the lowest clear bit of a row, found byte group first.
    function automatic logic [OFF_W-1:0] first_zero(input logic [ROW_W-1:0] w);
        logic [GRP_N-1:0]  grp_free;
        logic [GRP_W-1:0]  g;
        logic [BYTE_W-1:0] sel_byte;
        logic [BIT_W-1:0]  b;
        g = '0;
        b = '0;
        for (int i = 0; i < GRP_N; i++) begin
            grp_free[i] = ~&w[i*BYTE_W +: BYTE_W];
        end
        for (int i = GRP_N - 1; i >= 0; i--) begin
            if (grp_free[i]) begin
                g = GRP_W'(i);
            end
        end
        sel_byte = w[g*BYTE_W +: BYTE_W];
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            if (!sel_byte[i]) begin
                b = BIT_W'(i);
            end
        end
        return {g, b};
    endfunction

endpackage

`default_nettype wire

[rtl/bpa_controller.sv]
`default_nettype none

module bpa_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  bpa_pkg::t_ctl_sts i_sts,
    output bpa_pkg::t_ctl_cmd o_cmd
);
    import bpa_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   slot_free;

    // The output register can take a new word when empty or being drained.
    assign slot_free = !r_out_vld || !i_out_stall;

    // State register and output word valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_sts.early ? S_FINISH : S_APPLY;
            end
            S_APPLY: begin
                n_state = i_sts.need_scan ? S_SCAN : S_FINISH;
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands for the datapath.
    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
            end
            S_CHECK: begin
                o_cmd.early     = i_sts.early;
                o_cmd.rd_target = !i_sts.early;
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
            end
            S_SCAN: begin
                o_cmd.scan_rd  = 1'b1;
                o_cmd.scan_hit = i_sts.hit;
            end
            S_FINISH: begin
                o_cmd.load_out = slot_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_out_valid = r_out_vld;

endmodule

`default_nettype wire

[rtl/bpa_datapath.sv]
`default_nettype none

module bpa_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bpa_pkg::t_in_word  i_in_word,
    input  bpa_pkg::t_ctl_cmd  i_cmd,
    output bpa_pkg::t_ctl_sts  o_sts,
    output bpa_pkg::t_out_word o_out_word
);
    import bpa_pkg::*;

    // Captured word and allocator state.
    t_opcode          r_op;
    logic [PG_W-1:0]  r_idx;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_hint;

    // Bitmap rows with a valid flag per row; a row never written reads as all free.
    logic [ROW_W-1:0] r_mem [NUM_ROWS];
    logic [NUM_ROWS-1:0] r_row_vld;
    logic [ROW_W-1:0] r_rd_data;
    logic             r_rd_vld;

    // Scan pointer and the row whose data is being checked.
    logic [RA_W-1:0]  r_scan_row;
    logic [OFF_W-1:0] r_scan_off;
    logic             r_scan_first;
    logic             r_chk_vld;
    logic [RA_W-1:0]  r_chk_row;
    logic             r_chk_first;

    t_out_word        r_res;
    t_out_word        r_out;

    logic [PA_W-1:0]  idx_page;
    logic [PA_W-1:0]  hint_page;
    logic [PA_W-1:0]  tgt_page;
    logic [PA_W-1:0]  nxt_page;
    logic [RA_W-1:0]  tgt_row;
    logic [OFF_W-1:0] tgt_off;
    logic [RA_W-1:0]  rd_row;
    logic             rd_en;
    logic [ROW_W-1:0] row_data;
    logic [ROW_W-1:0] tgt_onehot;
    logic             tgt_bit;
    logic             idx_ok;
    logic             count_full;
    logic             hint_none;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] cnt_dec;
    logic             wr_en;
    logic [ROW_W-1:0] wr_data;
    logic [ROW_W-1:0] low_mask;
    logic [ROW_W-1:0] chk_mask;
    logic [OFF_W-1:0] chk_off;
    logic [PA_W-1:0]  hit_page;
    logic [RA_W-1:0]  scan_next;
    t_status          early_status;
    t_out_word        early_res;
    t_out_word        apply_res;

    // Addressing of the target page and of the page after it.
    assign idx_page   = PA_W'(r_idx);
    assign hint_page  = PA_W'(r_hint);
    assign tgt_page   = (r_op == OP_ALLOC) ? hint_page : idx_page;
    assign tgt_row    = tgt_page[PA_W-1:OFF_W];
    assign tgt_off    = tgt_page[OFF_W-1:0];
    assign nxt_page   = (hint_page == PA_W'(NUM_PAGES - 1)) ? '0 : hint_page + PA_W'(1);
    assign idx_ok     = (32'(r_idx) < 32'(NUM_PAGES));
    assign count_full = (r_count == CNT_W'(NUM_PAGES));
    assign hint_none  = (r_hint == CNT_W'(NUM_PAGES));
    assign cnt_inc    = r_count + CNT_W'(1);
    assign cnt_dec    = r_count - CNT_W'(1);

    // Read port: the target row, or the scan pointer while scanning.
    assign rd_row     = i_cmd.scan_rd ? r_scan_row : tgt_row;
    assign rd_en      = i_cmd.rd_target || i_cmd.scan_rd;
    assign row_data   = r_rd_vld ? r_rd_data : '0;
    assign tgt_onehot = ROW_W'(1) << tgt_off;
    assign tgt_bit    = row_data[tgt_off];

    // Write port: set the granted bit or clear the freed bit.
    assign wr_en   = i_cmd.apply &&
                     ((r_op == OP_ALLOC) || ((r_op == OP_FREE) && tgt_bit));
    assign wr_data = (r_op == OP_ALLOC) ? (row_data | tgt_onehot) : (row_data & ~tgt_onehot);

    // Scan check: bits below the start offset on the first visit and bits past
    // the end of the map count as used.
    assign low_mask  = (ROW_W'(1) << r_scan_off) - ROW_W'(1);
    assign chk_mask  = row_data
                     | ((r_chk_row == RA_W'(NUM_ROWS - 1)) ? LAST_MASK : '0)
                     | (r_chk_first ? low_mask : '0);
    assign chk_off   = first_zero(chk_mask);
    assign hit_page  = {r_chk_row, chk_off};
    assign scan_next = (r_scan_row == RA_W'(NUM_ROWS - 1)) ? '0 : r_scan_row + RA_W'(1);

    // Decisions that need no bitmap read.
    always_comb begin
        early_status    = ST_OK;
        o_sts.early     = 1'b0;
        unique case (r_op)
            OP_ALLOC: begin
                o_sts.early  = count_full;
                early_status = ST_FULL;
            end
            OP_FREE, OP_TEST: begin
                o_sts.early  = !idx_ok;
                early_status = ST_RANGE;
            end
            OP_NOP: begin
                o_sts.early  = 1'b1;
                early_status = ST_OK;
            end
        endcase
        o_sts.need_scan = (r_op == OP_ALLOC) && (cnt_inc != CNT_W'(NUM_PAGES));
        o_sts.hit       = r_chk_vld && !(&chk_mask);
    end

    // Result words for the early and the bitmap cases.
    always_comb begin
        early_res            = '0;
        early_res.status     = early_status;
        early_res.used_count = CNT_OUT_W'(r_count);

        apply_res            = '0;
        apply_res.used_count = CNT_OUT_W'(r_count);
        unique case (r_op)
            OP_ALLOC: begin
                apply_res.granted_page = PG_W'(hint_page);
                apply_res.used_count   = CNT_OUT_W'(cnt_inc);
            end
            OP_FREE: begin
                if (tgt_bit) begin
                    apply_res.used_count = CNT_OUT_W'(cnt_dec);
                end else begin
                    apply_res.status = ST_ALREADY_FREE;
                end
            end
            OP_TEST: begin
                apply_res.page_is_free = !tgt_bit;
            end
            OP_NOP: begin
                apply_res.status = ST_OK;
            end
        endcase
    end

    // Control state: count, hint and valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_hint    <= '0;
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
            r_chk_vld <= 1'b0;
        end else begin
            r_chk_vld <= i_cmd.scan_rd;
            if (rd_en) begin
                r_rd_vld <= r_row_vld[rd_row];
            end
            if (wr_en) begin
                r_row_vld[tgt_row] <= 1'b1;
            end
            if (i_cmd.apply) begin
                unique case (r_op)
                    OP_ALLOC: begin
                        r_count <= cnt_inc;
                        if (!o_sts.need_scan) begin
                            r_hint <= CNT_W'(NUM_PAGES);
                        end
                    end
                    OP_FREE: begin
                        if (tgt_bit) begin
                            r_count <= cnt_dec;
                            if (hint_none) begin
                                r_hint <= CNT_W'(r_idx);
                            end
                        end
                    end
                    OP_TEST, OP_NOP: begin
                    end
                endcase
            end
            if (i_cmd.scan_hit) begin
                r_hint <= CNT_W'(hit_page);
            end
        end
    end

    // Bitmap memory and datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_in_word.opcode;
            r_idx <= i_in_word.page_index;
        end
        if (wr_en) begin
            r_mem[tgt_row] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_row];
        end
        if (i_cmd.apply) begin
            r_scan_row   <= nxt_page[PA_W-1:OFF_W];
            r_scan_off   <= nxt_page[OFF_W-1:0];
            r_scan_first <= 1'b1;
        end else if (i_cmd.scan_rd) begin
            r_scan_row   <= scan_next;
            r_scan_first <= 1'b0;
        end
        if (i_cmd.scan_rd) begin
            r_chk_row   <= r_scan_row;
            r_chk_first <= r_scan_first;
        end
        if (i_cmd.early) begin
            r_res <= early_res;
        end else if (i_cmd.apply) begin
            r_res <= apply_res;
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    assign o_out_word = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(NUM_PAGES))
        else $error("page count exceeds the map size");

    a_hint_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hint_none == count_full)
        else $error("free hint is invalid while the map is not full, or the reverse");

    a_alloc_bit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.apply && (r_op == OP_ALLOC)) |-> !tgt_bit)
        else $error("hinted page is already in use");

    a_fresh_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.apply |-> $past(i_cmd.rd_target))
        else $error("update applied without a fresh row read");

endmodule

`default_nettype wire

[rtl/bitmap_page_allocator_unit.sv]
// Sequence: a free or test word passes the check, apply and finish states after acceptance
// and is then loaded into the output register; a no-op or rejected word skips apply. An
// allocate that leaves a page free adds bitmap scan states between apply and finish, and
// finish waits while the output register is full and stalled. A new word is taken only once
// the last leaves finish; scans read one 64-bit bitmap row per cycle via one read port.
// Reset: synchronous, active low; all pages free, count and hint zero, no clearing pass.
`default_nettype none

module bitmap_page_allocator_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bpa_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bpa_pkg::t_out_word  o_out_word
);
    import bpa_pkg::*;

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    // Sequencer for one word at a time.
    bpa_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Bitmap, counters and result registers.
    bpa_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_word (o_out_word)
    );

endmodule

`default_nettype wire
